// ----- rtl/vertex_component_to_float_macros.svh -----
// Assertion macros for the vertex component converter.
`ifndef VERTEX_COMPONENT_TO_FLOAT_MACROS_SVH
`define VERTEX_COMPONENT_TO_FLOAT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every clock edge outside reset
`define VCTF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vctf implication failed");
// Condition that must hold on every clock edge outside reset
`define VCTF_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("vctf invariant failed");
`else
`define VCTF_ASSERT_IMP(label, ante, cons)
`define VCTF_ASSERT_ALWAYS(label, cond)
`endif
`endif

// ----- rtl/vctf_pkg.sv -----
// Package for the vertex component converter: kind codes and helpers.
package vctf_pkg;

	localparam logic [2:0] KIND_UBYTE  = 3'd0;
	localparam logic [2:0] KIND_BYTE   = 3'd1;
	localparam logic [2:0] KIND_USHORT = 3'd2;
	localparam logic [2:0] KIND_SHORT  = 3'd3;
	localparam logic [2:0] KIND_UINT   = 3'd4;
	localparam logic [2:0] KIND_FLOAT  = 3'd5;

	localparam logic [1:0] REG_KIND = 2'd0;
	localparam logic [1:0] REG_NORM = 2'd1;

	// Divisor period for the repeating-fraction expansion
	localparam logic [1:0] PER_8  = 2'd0;
	localparam logic [1:0] PER_7  = 2'd1;
	localparam logic [1:0] PER_16 = 2'd2;
	localparam logic [1:0] PER_15 = 2'd3;

	localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
	localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
	localparam logic [31:0] FP_ZERO    = 32'h0000_0000;

	localparam logic [7:0] EXP_INT  = 8'd158;
	localparam logic [7:0] EXP_FRAC = 8'd126;

	// n/(2^m-1) is 0.nnnn... with an m-bit block repeating; n < 2^m-1
	function automatic logic [47:0] rep_frac(input logic [15:0] n, input logic [1:0] per);
		logic [47:0] w;
		w = '0;
		for (int i = 0; i < 48; i++) begin
			unique case (per)
				PER_8:  w[47-i] = n[7 - (i % 8)];
				PER_7:  w[47-i] = n[6 - (i % 7)];
				PER_16: w[47-i] = n[15 - (i % 16)];
				default: w[47-i] = n[14 - (i % 15)];
			endcase
		end
		return w;
	endfunction

	// Leading zero count of a nonzero 48-bit word
	function automatic logic [5:0] lzc48(input logic [47:0] w);
		logic [5:0] z;
		logic found;
		z = '0;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && w[i]) begin
				z = 6'(47 - i);
				found = 1'b1;
			end
		end
		return z;
	endfunction

endpackage

// ----- rtl/vertex_component_to_float.sv -----
// Vertex attribute component to single-precision float converter.
//
// Usage: pulse start with raw_bits while busy is low; one component is
// taken per cycle and busy never rises, so a new beat may follow in every
// cycle. Each beat gives exactly one result: result_valid is high for one
// cycle with float_bits, after the decode, normalize and pack registers.
// Throughput is one component per cycle; there are three register stages:
// decode (normalize-mode expansion of n/(2^m-1) or integer word), leading
// zero count and shift, then round to nearest even and pack.
// Configuration: cfg_index 0 selects the component kind, 1 the normalize
// flag; cfg_ready is always high, other indexes are dropped. Write only
// while no beat is in flight.
// Reset clears the registers to kind ubyte, normalize off, and empties the
// pipeline. The receiver cannot stall: results appear in order, one cycle
// each, and must be taken when shown.
`include "vertex_component_to_float_macros.svh"
module vertex_component_to_float
	import vctf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] raw_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	output logic        result_valid,
	output logic [31:0] float_bits
);

	typedef struct packed {
		logic        special;
		logic [31:0] spec_val;
		logic        neg;
		logic        force_sticky;
		logic [7:0]  exp_base;
	} ctl_t;

	logic [2:0]  kind_q;
	logic        norm_q;
	logic        acc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_UBYTE;
			norm_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_KIND) kind_q <= cfg_data;
			else if (cfg_index == REG_NORM) norm_q <= cfg_data[0];
		end
	end

	// Stage 1 decode
	ctl_t        ctl_d;
	logic [47:0] word_d;
	logic        sneg;
	logic [15:0] smag;
	logic [15:0] dmax;
	logic [1:0]  per;
	logic        is_signed;

	always_comb begin
		ctl_d = '{special: 1'b0, spec_val: FP_ZERO, neg: 1'b0, force_sticky: 1'b0,
			exp_base: EXP_INT};
		word_d    = '0;
		sneg      = 1'b0;
		smag      = '0;
		dmax      = 16'd255;
		per       = PER_8;
		is_signed = 1'b0;
		unique case (kind_q)
			KIND_UBYTE: begin
				smag = {8'd0, raw_bits[7:0]};
			end
			KIND_BYTE: begin
				is_signed = 1'b1;
				sneg = raw_bits[7];
				smag = {8'd0, sneg ? 8'(-raw_bits[7:0]) : raw_bits[7:0]};
				if (sneg && raw_bits[7:0] == 8'h80) smag = 16'd128;
				dmax = 16'd127;
				per  = PER_7;
			end
			KIND_USHORT: begin
				smag = raw_bits[15:0];
				dmax = 16'd65535;
				per  = PER_16;
			end
			KIND_SHORT: begin
				is_signed = 1'b1;
				sneg = raw_bits[15];
				smag = sneg ? 16'(-raw_bits[15:0]) : raw_bits[15:0];
				dmax = 16'd32767;
				per  = PER_15;
			end
			default: ;
		endcase
		ctl_d.neg = sneg;
		if (kind_q == KIND_UINT) begin
			word_d = {raw_bits, 16'd0};
			ctl_d.special = (raw_bits == 32'd0);
		end else if (kind_q == KIND_FLOAT) begin
			ctl_d.special  = 1'b1;
			ctl_d.spec_val = raw_bits;
		end else if (kind_q[2]) begin
			ctl_d.special = 1'b1;
		end else if (!norm_q) begin
			// Signed short -32768 has magnitude 32768, which fits 16 bits
			word_d = {16'd0, smag, 16'd0};
			ctl_d.special = (smag == 16'd0);
		end else begin
			ctl_d.exp_base     = EXP_FRAC;
			ctl_d.force_sticky = 1'b1;
			word_d = rep_frac(smag, per);
			if (smag == 16'd0) begin
				ctl_d.special = 1'b1;
			end else if (is_signed && sneg && smag >= dmax) begin
				ctl_d.special  = 1'b1;
				ctl_d.spec_val = FP_NEG_ONE;
			end else if (smag == dmax) begin
				ctl_d.special  = 1'b1;
				ctl_d.spec_val = FP_ONE;
			end
		end
	end

	logic        valid_s1;
	ctl_t        ctl_s1;
	logic [47:0] word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		ctl_s1  <= ctl_d;
		word_s1 <= word_d;
	end

	// Stage 2 normalize
	logic [5:0]  lz;
	logic        valid_s2;
	ctl_t        ctl_s2;
	logic [47:0] word_s2;
	logic [7:0]  exp_s2;

	assign lz = lzc48(word_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl_s1;
		word_s2 <= word_s1 << lz;
		exp_s2  <= ctl_s1.exp_base - {2'd0, lz};
	end

	// Stage 3 round to nearest even and pack
	logic        guard;
	logic        sticky;
	logic        rnd_up;
	logic [24:0] sig_r;
	logic [7:0]  exp_r;
	logic [31:0] packed_r;

	always_comb begin
		guard  = word_s2[23];
		sticky = ctl_s2.force_sticky || (|word_s2[22:0]);
		rnd_up = guard && (sticky || word_s2[24]);
		sig_r  = {1'b0, word_s2[47:24]} + {24'd0, rnd_up};
		exp_r  = exp_s2 + {7'd0, sig_r[24]};
		packed_r = {ctl_s2.neg, exp_r, sig_r[24] ? 23'd0 : sig_r[22:0]};
		if (ctl_s2.special) packed_r = ctl_s2.spec_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else         result_valid <= valid_s2;
	end

	always_ff @(posedge clk) begin
		float_bits <= packed_r;
	end

	`VCTF_ASSERT_IMP(a_latency, start && !busy, ##3 result_valid)
	`VCTF_ASSERT_IMP(a_no_spurious, result_valid, $past(start && !busy, 3))
	`VCTF_ASSERT_IMP(a_float_pass, start && !busy && kind_q == KIND_FLOAT,
		##3 (float_bits == $past(raw_bits, 3)))
	`VCTF_ASSERT_ALWAYS(a_never_busy, !busy && cfg_ready)

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the vertex component to float converter.
module tb_top;
	import vctf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] raw_bits;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [2:0]  cfg_data;
	logic        result_valid;
	logic [31:0] float_bits;

	// Shadow configuration used by the predictor
	logic [2:0]  kind_sh;
	logic        norm_sh;

	logic [31:0] float_q[$];
	int          n_err;
	int          idle_cycles;
	bit          timed_out;

	localparam int WATCHDOG = 2000;

	vertex_component_to_float u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .raw_bits(raw_bits),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .float_bits(float_bits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Round a nonzero magnitude to single precision, nearest even
	function automatic logic [31:0] mag_to_fp(input logic [31:0] mag, input logic neg);
		int p;
		logic [31:0] q, rem, half;
		int s;
		if (mag == 0) return 32'h0;
		p = 31;
		while (!mag[p]) p--;
		if (p <= 23) begin
			q = mag << (23 - p);
		end else begin
			s = p - 23;
			rem = mag & ((32'd1 << s) - 1);
			half = 32'd1 << (s - 1);
			q = mag >> s;
			if (rem > half || (rem == half && q[0])) q++;
			if (q == 32'h0100_0000) begin
				q = q >> 1;
				p++;
			end
		end
		return {neg, 8'(127 + p), q[22:0]};
	endfunction

	// Correctly rounded n/d for 0 < n <= d
	function automatic logic [31:0] ratio_to_fp(input logic [31:0] n, input logic [31:0] d,
			input logic neg);
		int k;
		logic [63:0] num, q, r;
		if (n == 0) return 32'h0;
		if (n > d) return neg ? FP_NEG_ONE : FP_ONE;
		k = 0;
		while (k < 48 && ((64'(n) << k) / d) < 64'h80_0000) k++;
		num = 64'(n) << k;
		q = num / d;
		r = num % d;
		if (2 * r > d || (2 * r == d && q[0])) q++;
		if (q == 64'h100_0000) begin
			q = q >> 1;
			k--;
		end
		return {neg, 8'(150 - k), q[22:0]};
	endfunction

	function automatic logic [31:0] signed_to_fp(input logic [31:0] raw, input int bits,
			input logic [31:0] dmax);
		logic [31:0] v, mag;
		logic neg;
		v = raw & ((32'd1 << bits) - 1);
		neg = v[bits-1];
		mag = neg ? ((32'd1 << bits) - v) : v;
		if (!norm_sh) return mag_to_fp(mag, neg);
		if (neg && mag >= dmax) return FP_NEG_ONE;
		return ratio_to_fp(mag, dmax, neg);
	endfunction

	function automatic logic [31:0] convert_component(input logic [31:0] raw);
		case (kind_sh)
			KIND_UBYTE:  return norm_sh ? ratio_to_fp(32'(raw[7:0]), 32'd255, 1'b0)
				: mag_to_fp(32'(raw[7:0]), 1'b0);
			KIND_BYTE:   return signed_to_fp(raw, 8, 32'd127);
			KIND_USHORT: return norm_sh ? ratio_to_fp(32'(raw[15:0]), 32'd65535, 1'b0)
				: mag_to_fp(32'(raw[15:0]), 1'b0);
			KIND_SHORT:  return signed_to_fp(raw, 16, 32'd32767);
			KIND_UINT:   return mag_to_fp(raw, 1'b0);
			KIND_FLOAT:  return raw;
			default:     return FP_ZERO;
		endcase
	endfunction

	// Random gap: mostly none or short, a few long; start drops only for a real gap
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50) return;
		n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		start <= 1'b0;
		raw_bits <= $urandom;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_component(input logic [31:0] raw, input bit gaps);
		start <= 1'b1;
		raw_bits <= raw;
		float_q.push_back(convert_component(raw));
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gaps && $urandom_range(0, 3) == 0) idle_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (float_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_KIND) kind_sh = val;
		else if (idx == REG_NORM) norm_sh = val[0];
	endtask

	task automatic set_mode(input logic [2:0] k, input logic n);
		write_reg(REG_KIND, k);
		write_reg(REG_NORM, {2'b0, n});
		cfg_valid <= 1'b0;
	endtask

	// Directed: field extremes, clamp values, passthrough, unused kinds
	task automatic test_directed();
		logic [31:0] pats[8];
		pats = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0080, 32'h0000_8000,
			32'h0000_007F, 32'h0000_7FFF, 32'h7FC0_0001, 32'hFFFF_FF01};
		for (int m = 0; m < 16; m++) begin
			set_mode(m[3:1], m[0]);
			for (int i = 0; i < (m < 12 ? 3 : 1); i++)
				send_component(pats[$urandom_range(0, 7)], 1'b0);
			send_component(pats[m % 8], 1'b0);
			drain();
		end
	endtask

	// Random: cycle through modes, with stretches of back-to-back beats
	task automatic test_random();
		logic [31:0] v;
		for (int ph = 0; ph < 34; ph++) begin
			set_mode(ph < 2 ? 3'(ph * 7) : 3'($urandom_range(0, 7)),
				ph < 2 ? 1'(ph) : 1'($urandom_range(0, 1)));
			for (int i = 0; i < 50; i++) begin
				case ($urandom_range(0, 3))
					0: v = $urandom & 32'hFF;
					1: v = $urandom & 32'hFFFF;
					2: v = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
					default: v = $urandom;
				endcase
				send_component(v, ph % 5 != 0);
			end
			drain();
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && result_valid) begin
			if (float_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result %h", float_bits);
			end else begin
				want = float_q.pop_front();
				if (float_bits !== want) begin
					n_err++;
					if (n_err <= 10)
						$display("float_bits mismatch: expected %h got %h", want, float_bits);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat, result or configuration write
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) timed_out = 1'b1;
	end

	initial begin
		n_err = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		raw_bits = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		kind_sh = KIND_UBYTE;
		norm_sh = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			begin
				test_directed();
				test_random();
				drain();
			end
			wait (timed_out);
		join_any
		if (timed_out) begin
			$display("tb_top failed");
		end else if (n_err == 0 && float_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/vctf_pkg.sv
rtl/vertex_component_to_float.sv
sim/tb_top.sv
